FILE: rtl/swam_pkg.sv
// Shared types and constants for the sliding-window anagram matcher.
package swam_pkg;

  // Field widths of the item and result transfers.
  localparam int REQ_W    = 2;
  localparam int LETTER_W = 5;
  localparam int POS_W    = 32;

  // Request codes carried in req_type.
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_NONE    = 2'd3
  } swam_req_e;

  // Histogram update handed from the front stage to the letter counters.
  typedef struct packed {
    logic                clear;
    logic                dec_ch;
    logic                inc_ch;
    logic                drop_old;
    logic [LETTER_W-1:0] ch;
  } swam_hist_op_t;

endpackage

FILE: rtl/swam_item_if.sv
// Input channel interface: request type and letter with valid/ready.
interface swam_item_if;
  import swam_pkg::*;

  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, output req_type, output letter, input ready);
  modport sink   (input valid, input req_type, input letter, output ready);
endinterface

FILE: rtl/swam_result_if.sv
// Result channel interface: match start index with valid/ready.
interface swam_result_if;
  import swam_pkg::*;

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface

FILE: rtl/sliding_window_anagram_matcher.sv
// Top level of the sliding-window anagram matcher.
//
// Usage: items arrive on item_i (valid/ready). A clear request resets the
// counters and histogram, pattern letters build the pattern histogram, text
// letters slide a window of pattern length over the text. Whenever the window
// is full and is a permutation of the pattern, the window's start index is sent
// as one transfer on result_o (valid/ready). An empty pattern never gives results.
//
// Timing: one item per cycle while item_i is ready. The front stage updates
// the counters and the ring buffer and reads the departing letter; the ring
// memory's registered read sets a second stage where the letter balances are
// updated. A result is found in the second stage and loaded from there into
// the output register, from which it is sent as its own transfer on result_o.
// Reset leaves the histogram and all counters at zero; the ring memory
// needs no clearing since a slot is always written before its letter is used.
// While result_o stalls with a result waiting, items that give no result
// still flow; the input stalls only when a second result is ready.
module sliding_window_anagram_matcher #(
  parameter int MAX_PATTERN = 256,
  parameter int ALPHABET    = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swam_item_if.sink     item_i,
  swam_result_if.source result_o
);
  import swam_pkg::*;

  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int BAL_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] PatMax = CNT_W'(MAX_PATTERN);
  localparam logic [CNT_W:0]   Depth  = (CNT_W + 1)'(MAX_PATTERN);

  // Front-stage control state.
  logic [PTR_W-1:0] head_q;
  logic [CNT_W-1:0] fill_q;
  logic [CNT_W-1:0] plen_q;
  logic [POS_W-1:0] pos_q;

  // Second stage and output register.
  logic             s2_valid_q;
  swam_hist_op_t    s2_op_q;
  logic             s2_cand_q;
  logic [POS_W-1:0] s2_start_q;
  logic             out_valid_q;
  logic [POS_W-1:0] out_data_q;

  logic             accept;
  logic             letter_ok;
  logic             is_clear;
  logic             is_text;
  logic             pat_take;
  logic             text_store;
  logic             full;
  logic             cand_d;
  swam_hist_op_t    op_d;
  logic [CNT_W:0]   wsum;
  logic [CNT_W:0]   wslot;
  logic [CNT_W:0]   head_inc;
  logic [CNT_W:0]   fill_inc;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] head_next;
  logic [POS_W:0]   here1;
  logic [POS_W:0]   plen_ext;
  logic [POS_W:0]   start_diff;
  logic [POS_W-1:0] start_d;
  logic [LETTER_W-1:0] old_letter;
  logic             hist_zero;
  logic             produce;
  logic             s2_adv;

  // Decode the request and work out ring slots and the window start.
  always_comb begin
    letter_ok  = 32'(item_i.letter) < 32'(ALPHABET);
    is_clear   = item_i.req_type == REQ_CLEAR;
    is_text    = (item_i.req_type == REQ_TEXT) && letter_ok;
    pat_take   = (item_i.req_type == REQ_PATTERN) && letter_ok && (plen_q < PatMax);
    text_store = is_text && (plen_q != '0);
    full       = fill_q == plen_q;
    fill_inc   = {1'b0, fill_q} + (CNT_W + 1)'(1);
    cand_d     = text_store && (full || (fill_inc == {1'b0, plen_q}));

    wsum  = (CNT_W + 1)'(head_q) + {1'b0, fill_q};
    wslot = (wsum >= Depth) ? (wsum - Depth) : wsum;
    waddr = wslot[PTR_W-1:0];

    head_inc  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(1);
    head_next = (head_inc >= Depth) ? '0 : head_inc[PTR_W-1:0];

    here1      = {1'b0, pos_q} + (POS_W + 1)'(1);
    plen_ext   = (POS_W + 1)'(plen_q);
    start_diff = here1 - plen_ext;
    start_d    = (here1 >= plen_ext) ? start_diff[POS_W-1:0] : '0;

    op_d.clear    = is_clear;
    op_d.dec_ch   = pat_take;
    op_d.inc_ch   = text_store;
    op_d.drop_old = text_store && full;
    op_d.ch       = item_i.letter;
  end

  // A result leaves the second stage only if the output register can take it.
  assign produce = s2_valid_q && s2_cand_q && hist_zero;
  assign s2_adv  = !s2_valid_q || !produce || !out_valid_q || result_o.ready;
  assign accept  = item_i.valid && s2_adv;

  assign item_i.ready         = s2_adv;
  assign result_o.valid       = out_valid_q;
  assign result_o.match_start = out_data_q;

  // Window letter storage; the departing letter is read at the head slot.
  swam_ring #(
    .DEPTH (MAX_PATTERN)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && text_store),
    .waddr_i (waddr),
    .wdata_i (item_i.letter),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (old_letter)
  );

  // Letter balances, updated in item order by the second stage.
  swam_hist #(
    .ALPHABET (ALPHABET),
    .BAL_W    (BAL_W)
  ) u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .apply_i (s2_valid_q && s2_adv),
    .op_i    (s2_op_q),
    .old_i   (old_letter),
    .zero_o  (hist_zero)
  );

  // Front-stage counters: ring head, window fill, pattern length, position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      plen_q <= '0;
      pos_q  <= '0;
    end else if (accept) begin
      if (is_clear) begin
        head_q <= '0;
        fill_q <= '0;
        plen_q <= '0;
        pos_q  <= '0;
      end else if (pat_take) begin
        plen_q <= plen_q + CNT_W'(1);
      end else if (is_text) begin
        if (pos_q != '1) begin
          pos_q <= pos_q + POS_W'(1);
        end
        if (text_store) begin
          if (full) begin
            head_q <= head_next;
          end else begin
            fill_q <= fill_inc[CNT_W-1:0];
          end
        end
      end
    end
  end

  // Second-stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= accept;
    end
  end

  // Second-stage payload, loaded with each accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_op_q    <= op_d;
      s2_cand_q  <= cand_d;
      s2_start_q <= start_d;
    end
  end

  // Output register holding one result until its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce && s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce && s2_adv) begin
      out_data_q <= s2_start_q;
    end
  end

endmodule

FILE: rtl/swam_ring.sv
// Ring buffer memory for the window text letters, one write and one read port.
module swam_ring #(
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [swam_pkg::LETTER_W-1:0]         wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [swam_pkg::LETTER_W-1:0]         rdata_o
);
  import swam_pkg::*;

  logic [LETTER_W-1:0] mem [DEPTH];
  logic [LETTER_W-1:0] rdata_q;

  // Read-first port: a read and write of the same slot returns the old letter.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/swam_hist.sv
// Signed per-letter balance counters and the all-zero detector.
module swam_hist #(
  parameter int ALPHABET = 26,
  parameter int BAL_W    = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          apply_i,
  input  swam_pkg::swam_hist_op_t       op_i,
  input  logic [swam_pkg::LETTER_W-1:0] old_i,
  output logic                          zero_o
);
  import swam_pkg::*;

  logic signed [BAL_W-1:0] bal_q [ALPHABET];
  logic signed [BAL_W-1:0] bal_d [ALPHABET];

  // Each lane adds one for the entering letter and subtracts one for a
  // pattern letter or the letter that leaves the window.
  always_comb begin
    logic hit_inc;
    logic hit_dec;
    zero_o = 1'b1;
    for (int i = 0; i < ALPHABET; i++) begin
      hit_inc = op_i.inc_ch && (32'(op_i.ch) == 32'(i));
      hit_dec = (op_i.dec_ch && (32'(op_i.ch) == 32'(i))) ||
                (op_i.drop_old && (32'(old_i) == 32'(i)));
      if (op_i.clear) begin
        bal_d[i] = '0;
      end else begin
        bal_d[i] = bal_q[i] + BAL_W'(hit_inc) - BAL_W'(hit_dec);
      end
      if (bal_d[i] != '0) begin
        zero_o = 1'b0;
      end
    end
  end

  // Lane registers advance only when the pending update is applied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALPHABET; i++) begin
        bal_q[i] <= '0;
      end
    end else if (apply_i) begin
      for (int i = 0; i < ALPHABET; i++) begin
        bal_q[i] <= bal_d[i];
      end
    end
  end

endmodule
